// ===== hdl/qlg_pkg.sv =====
`timescale 1ns / 1ps

package qlg_pkg;

    localparam int VAL_W  = 16;   // one Q8.8 value
    localparam int WORD_W = 64;   // four action values per cell
    localparam int CFG_W  = 9;    // widest configuration register
    localparam int DEST_W = 13;   // signed destination, covers tables up to 4096 cells
    localparam int SUM_W  = 18;   // reward*256 + discounted max
    localparam int PROD_W = 28;   // 10 x 18 signed product

    localparam logic [8:0] RATE_ONE = 9'd256;

    // configuration register indexes
    localparam logic [1:0] REG_LEARN_RATE  = 2'd0;
    localparam logic [1:0] REG_DISCOUNT    = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH   = 2'd2;
    localparam logic [1:0] REG_START_STATE = 2'd3;

    // move codes
    localparam logic [1:0] ACT_ROW_PLUS  = 2'd0;
    localparam logic [1:0] ACT_RIGHT     = 2'd1;
    localparam logic [1:0] ACT_ROW_MINUS = 2'd2;
    localparam logic [1:0] ACT_LEFT      = 2'd3;

    typedef struct packed {
        logic [7:0]        current_state;
        logic [1:0]        action;
        logic signed [7:0] reward;
    } item_t;

    typedef struct packed {
        logic [7:0]         next_state;
        logic signed [15:0] new_value;
        logic [1:0]         best_next_action;
        logic               episode_end;
        logic               off_grid;
    } result_t;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_RD_DEST = 8'b0000_0100,
        ST_RD_CUR  = 8'b0000_1000,
        ST_MUL_G   = 8'b0001_0000,
        ST_MUL_Q   = 8'b0010_0000,
        ST_MUL_A   = 8'b0100_0000,
        ST_WRITE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic in_ready;      // waiting for an item
        logic clearing;      // table clear sweep running
        logic sel_cur_addr;  // read port on the current cell
        logic take_dest;     // destination word on read data
        logic take_cur;      // current word on read data, discount multiply
        logic mul_q;         // keep-part multiply
        logic mul_a;         // learning-rate multiply
        logic finish;        // sum, saturate, write back
    } ctl_t;

endpackage

// ===== hdl/qlg_ram.sv =====
`timescale 1ns / 1ps

module qlg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/qlg_mul.sv =====
`timescale 1ns / 1ps

// shared 10 x 18 signed multiplier with registered product
module qlg_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [8:0]                            a,
    input  logic signed [qlg_pkg::SUM_W-1:0]      b,
    output logic signed [qlg_pkg::PROD_W-1:0]     prod
);

    logic signed [qlg_pkg::PROD_W-1:0] prod_reg;
    logic signed [qlg_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = $signed({1'b0, a}) * b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/qlg_ctrl.sv =====
`timescale 1ns / 1ps

module qlg_ctrl #(
    parameter int NUM_STATES = 256
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               item_valid,
    input  logic                                               out_free,
    output qlg_pkg::ctl_t                                      ctl,
    output logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] clr_addr
);

    localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_STATES - 1);

    qlg_pkg::state_t state_reg;
    qlg_pkg::state_t state_next;
    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   clr_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            qlg_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST)
                begin
                    state_next = qlg_pkg::ST_IDLE;
                end
            end
            qlg_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = qlg_pkg::ST_RD_DEST;
                end
            end
            qlg_pkg::ST_RD_DEST: state_next = qlg_pkg::ST_RD_CUR;
            qlg_pkg::ST_RD_CUR:  state_next = qlg_pkg::ST_MUL_G;
            qlg_pkg::ST_MUL_G:   state_next = qlg_pkg::ST_MUL_Q;
            qlg_pkg::ST_MUL_Q:   state_next = qlg_pkg::ST_MUL_A;
            qlg_pkg::ST_MUL_A:   state_next = qlg_pkg::ST_WRITE;
            qlg_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = qlg_pkg::ST_IDLE;
                end
            end
            default:             state_next = qlg_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qlg_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        ctl.in_ready     = (state_reg == qlg_pkg::ST_IDLE);
        ctl.clearing     = (state_reg == qlg_pkg::ST_CLEAR);
        ctl.sel_cur_addr = (state_reg == qlg_pkg::ST_RD_CUR);
        ctl.take_dest    = (state_reg == qlg_pkg::ST_RD_CUR);
        ctl.take_cur     = (state_reg == qlg_pkg::ST_MUL_G);
        ctl.mul_q        = (state_reg == qlg_pkg::ST_MUL_Q);
        ctl.mul_a        = (state_reg == qlg_pkg::ST_MUL_A);
        ctl.finish       = (state_reg == qlg_pkg::ST_WRITE);
    end

    assign clr_addr = clr_cnt_reg;

endmodule

// ===== hdl/q_learning_grid_update.sv =====
`timescale 1ns / 1ps

// sequence: RD_DEST, RD_CUR, MUL_G, MUL_Q, MUL_A, then WRITE, which waits for a free result
//   slot; result_valid is registered from the write back; one item at a time, set by the
//   sequencer sharing the value table's one read port (two reads, then one write) and the
//   one shared multiplier (three products); reset: async active low, then a clear sweep
//   writes zero to all NUM_STATES cells, one per cycle, with item_ready low until it ends
// configuration registers reset to learn_rate 128, discount 230, row_width 10, start 11
module q_learning_grid_update #(
    parameter int NUM_STATES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item channel
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  qlg_pkg::item_t                        item,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output qlg_pkg::result_t                      result,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [qlg_pkg::CFG_W-1:0]             cfg_data
);

    localparam int AW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [8:0] learn_rate_reg;
    logic [8:0] discount_reg;
    logic [8:0] row_width_reg;
    logic [7:0] start_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg  <= 9'd128;
            discount_reg    <= 9'd230;
            row_width_reg   <= 9'd10;
            start_state_reg <= 8'd11;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qlg_pkg::REG_LEARN_RATE:  learn_rate_reg  <= cfg_data;
                qlg_pkg::REG_DISCOUNT:    discount_reg    <= cfg_data;
                qlg_pkg::REG_ROW_WIDTH:   row_width_reg   <= cfg_data;
                qlg_pkg::REG_START_STATE: start_state_reg <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    qlg_pkg::ctl_t  ctl;
    logic [AW-1:0]  clr_addr;
    logic           out_free;
    logic           item_xfer;

    // result slot is free when empty or being drained this cycle
    assign out_free  = !result_valid || result_ready;
    assign item_xfer = item_valid && item_ready;

    qlg_ctrl #(
        .NUM_STATES (NUM_STATES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .out_free   (out_free),
        .ctl        (ctl),
        .clr_addr   (clr_addr)
    );

    assign item_ready = ctl.in_ready;

    // ------------------------------------------------------------------
    // item capture: destination computed on transfer, rates clamped to 1.0
    // ------------------------------------------------------------------
    logic [7:0]                               cur_reg;
    logic [1:0]                               act_reg;
    logic signed [7:0]                        reward_reg;
    logic [8:0]                               alpha_reg;
    logic [8:0]                               gamma_reg;
    logic signed [qlg_pkg::DEST_W-1:0]        dest_reg;
    logic signed [qlg_pkg::DEST_W-1:0]        dest_next;
    logic signed [qlg_pkg::DEST_W-1:0]        cur_ext;
    logic signed [qlg_pkg::DEST_W-1:0]        row_ext;

    always_comb
    begin
        cur_ext = $signed({5'd0, item.current_state});
        row_ext = $signed({4'd0, row_width_reg});
        unique case (item.action)
            qlg_pkg::ACT_ROW_PLUS:  dest_next = cur_ext + row_ext;
            qlg_pkg::ACT_RIGHT:     dest_next = cur_ext + 13'sd1;
            qlg_pkg::ACT_ROW_MINUS: dest_next = cur_ext - row_ext;
            qlg_pkg::ACT_LEFT:      dest_next = cur_ext - 13'sd1;
            default:                dest_next = cur_ext;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            cur_reg    <= item.current_state;
            act_reg    <= item.action;
            reward_reg <= item.reward;
            dest_reg   <= dest_next;
            alpha_reg  <= (learn_rate_reg > qlg_pkg::RATE_ONE) ? qlg_pkg::RATE_ONE
                                                               : learn_rate_reg;
            gamma_reg  <= (discount_reg > qlg_pkg::RATE_ONE) ? qlg_pkg::RATE_ONE
                                                             : discount_reg;
        end
    end

    // destination outside the table, current cell inside it
    logic off_w;
    logic cur_in;

    assign off_w  = dest_reg[qlg_pkg::DEST_W-1]
                 || (32'(dest_reg[qlg_pkg::DEST_W-2:0]) >= 32'(NUM_STATES));
    assign cur_in = 32'(cur_reg) < 32'(NUM_STATES);

    // ------------------------------------------------------------------
    // value table: destination read, then current read, then write back
    // ------------------------------------------------------------------
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [qlg_pkg::WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [qlg_pkg::WORD_W-1:0]    ram_rdata;
    logic [qlg_pkg::WORD_W-1:0]    wr_word;
    logic                          commit;

    // write back only when the result can also be handed over
    assign commit    = ctl.finish && out_free;
    assign ram_we    = ctl.clearing || (commit && cur_in);
    assign ram_waddr = ctl.clearing ? clr_addr : AW'(cur_reg);
    assign ram_wdata = ctl.clearing ? '0 : wr_word;
    assign ram_raddr = ctl.sel_cur_addr ? AW'(cur_reg) : dest_reg[AW-1:0];

    qlg_ram #(
        .WIDTH (qlg_pkg::WORD_W),
        .DEPTH (NUM_STATES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // best action of the destination word, first maximum wins
    // ------------------------------------------------------------------
    logic signed [qlg_pkg::VAL_W-1:0] dmax;
    logic [1:0]                       dbest;

    always_comb
    begin
        dmax  = $signed(ram_rdata[qlg_pkg::VAL_W-1:0]);
        dbest = 2'd0;
        for (int k = 1; k < 4; k++)
        begin
            if ($signed(ram_rdata[k*qlg_pkg::VAL_W +: qlg_pkg::VAL_W]) > dmax)
            begin
                dmax  = $signed(ram_rdata[k*qlg_pkg::VAL_W +: qlg_pkg::VAL_W]);
                dbest = 2'(k);
            end
        end
    end

    logic signed [qlg_pkg::VAL_W-1:0]  maxv_reg;
    logic [1:0]                        best_reg;
    logic                              off_reg;
    logic [qlg_pkg::WORD_W-1:0]        cur_word_reg;
    logic signed [qlg_pkg::VAL_W-1:0]  q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take_dest)
        begin
            // off the grid: max counts as zero, best action reported as zero
            off_reg  <= off_w;
            maxv_reg <= off_w ? '0 : dmax;
            best_reg <= off_w ? 2'd0 : dbest;
        end
        if (ctl.take_cur)
        begin
            cur_word_reg <= ram_rdata;
            q_reg        <= cur_in ? $signed(ram_rdata[{act_reg, 4'd0} +: qlg_pkg::VAL_W])
                                   : '0;
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier: gamma*max, then (1-alpha)*q, then alpha*target
    // ------------------------------------------------------------------
    logic [8:0]                         mul_a;
    logic signed [qlg_pkg::SUM_W-1:0]   mul_b;
    logic signed [qlg_pkg::PROD_W-1:0]  prod;
    logic signed [qlg_pkg::PROD_W-1:0]  prod_sh;
    logic signed [qlg_pkg::SUM_W-1:0]   sum_reg;
    logic signed [qlg_pkg::PROD_W-1:0]  acc_reg;

    always_comb
    begin
        priority if (ctl.mul_q)
        begin
            mul_a = qlg_pkg::RATE_ONE - alpha_reg;
            mul_b = qlg_pkg::SUM_W'(q_reg);
        end
        else if (ctl.mul_a)
        begin
            mul_a = alpha_reg;
            mul_b = sum_reg;
        end
        else
        begin
            mul_a = gamma_reg;
            mul_b = qlg_pkg::SUM_W'(maxv_reg);
        end
    end

    qlg_mul u_mul (
        .clk  (clk),
        .en   (ctl.take_cur || ctl.mul_q || ctl.mul_a),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // arithmetic shift is the floor division by 256
    assign prod_sh = prod >>> 8;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_q)
        begin
            // target = reward*256 + floor(gamma*max/256)
            sum_reg <= prod_sh[qlg_pkg::SUM_W-1:0]
                     + $signed({{2{reward_reg[7]}}, reward_reg, 8'd0});
        end
        if (ctl.mul_a)
        begin
            acc_reg <= prod;
        end
    end

    // ------------------------------------------------------------------
    // final sum, floor, saturate to 16 bits, merge into the cell word
    // ------------------------------------------------------------------
    logic signed [qlg_pkg::PROD_W:0]    total;
    logic signed [qlg_pkg::PROD_W-8:0]  scaled;
    logic signed [qlg_pkg::VAL_W-1:0]   new_val;

    always_comb
    begin
        total  = {acc_reg[qlg_pkg::PROD_W-1], acc_reg} + {prod[qlg_pkg::PROD_W-1], prod};
        scaled = total[qlg_pkg::PROD_W:8];
        if (scaled > $signed(21'sd32767))
        begin
            new_val = 16'sh7FFF;
        end
        else if (scaled < -$signed(21'sd32768))
        begin
            new_val = -16'sh8000;
        end
        else
        begin
            new_val = scaled[qlg_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            wr_word[k*qlg_pkg::VAL_W +: qlg_pkg::VAL_W] =
                (2'(k) == act_reg) ? new_val
                                   : cur_word_reg[k*qlg_pkg::VAL_W +: qlg_pkg::VAL_W];
        end
    end

    // ------------------------------------------------------------------
    // result register: parts the sequencer from the result channel
    // ------------------------------------------------------------------
    logic              result_valid_reg;
    qlg_pkg::result_t  result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            // nonzero reward ends the episode and sends the agent to the start cell
            result_reg.episode_end      <= (reward_reg != 8'sd0);
            result_reg.next_state       <= (reward_reg != 8'sd0) ? start_state_reg
                                                                 : dest_reg[7:0];
            result_reg.new_value        <= new_val;
            result_reg.best_next_action <= best_reg;
            result_reg.off_grid         <= off_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> !item_ready)
        else $error("second item taken while one is in work");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> result_valid)
        else $error("write back without a result");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !item_ready)
        else $error("table written while waiting for an item");

    a_off_best: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.off_grid) |-> (result.best_next_action == 2'd0))
        else $error("best action reported for a destination off the grid");

endmodule

// ===== tb/q_learning_grid_update_tb.sv =====
`timescale 1ns / 1ps

module q_learning_grid_update_tb;

    localparam int NUM_CELLS    = 256;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // idle margin after every expected result is back

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_ready;
    qlg_pkg::item_t                item;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    qlg_pkg::result_t              result;
    logic                          cfg_wr_en;
    logic [1:0]                    cfg_index;
    logic [qlg_pkg::CFG_W-1:0]     cfg_data;

    // shadow of the value table and the registers
    logic [qlg_pkg::WORD_W-1:0]    q_table [NUM_CELLS];
    logic [8:0]                    alpha_reg;
    logic [8:0]                    gamma_reg;
    logic [8:0]                    row_reg;
    logic [7:0]                    start_reg;

    qlg_pkg::result_t              expected_updates [$];
    qlg_pkg::result_t              want;
    logic [7:0]                    agent_pos;

    int                   n_steps;
    int                   n_results;
    int                   n_ends;
    int                   n_off;
    int                   n_sat;
    int                   n_settings;
    int                   mismatches;
    int                   cycle_count;

    bit                   tx_idle_en;
    bit                   rx_idle_en;
    int                   hold_reqs;
    int                   hold_seen;
    int                   hold_left;
    int                   rx_gap;

    q_learning_grid_update #(
        .NUM_STATES(NUM_CELLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // one q-learning step on the shadow table, returns the expected result
    function automatic qlg_pkg::result_t predict_q_update(input qlg_pkg::item_t it);
        longint                     cur;
        longint                     dest;
        longint                     rw;
        longint                     a;
        longint                     g;
        longint                     best_v;
        longint                     v;
        longint                     q;
        longint                     nv;
        int                         best;
        int                         k;
        logic [qlg_pkg::WORD_W-1:0] w;
        qlg_pkg::result_t           r;
        cur = it.current_state;
        rw  = row_reg;
        a   = (alpha_reg > qlg_pkg::RATE_ONE) ? 256 : alpha_reg;
        g   = (gamma_reg > qlg_pkg::RATE_ONE) ? 256 : gamma_reg;
        case (it.action)
            qlg_pkg::ACT_ROW_PLUS:  dest = cur + rw;
            qlg_pkg::ACT_RIGHT:     dest = cur + 1;
            qlg_pkg::ACT_ROW_MINUS: dest = cur - rw;
            default:                dest = cur - 1;
        endcase
        r.off_grid = (dest < 0 || dest >= NUM_CELLS);
        // max over the destination cell, lowest action wins a tie
        best_v = 0;
        best   = 0;
        if (!r.off_grid)
        begin
            w      = q_table[dest];
            best_v = $signed(w[15:0]);
            for (k = 1; k < 4; k++)
            begin
                v = $signed(w[16*k +: 16]);
                if (v > best_v)
                begin
                    best_v = v;
                    best   = k;
                end
            end
        end
        q  = $signed(q_table[cur][16*it.action +: 16]);
        // arithmetic shifts floor toward minus infinity
        nv = ((256 - a) * q + a * (longint'(it.reward) * 256 + ((g * best_v) >>> 8))) >>> 8;
        if (nv > 32767)
        begin
            nv = 32767;
            n_sat++;
        end
        else if (nv < -32768)
        begin
            nv = -32768;
            n_sat++;
        end
        q_table[cur][16*it.action +: 16] = nv[15:0];
        r.new_value        = nv[15:0];
        r.best_next_action = best[1:0];
        r.episode_end      = (it.reward != 0);
        r.next_state       = r.episode_end ? start_reg : dest[7:0];
        if (r.episode_end)
            n_ends++;
        if (r.off_grid)
            n_off++;
        return r;
    endfunction

    // offer one step, hold it until the transfer, then queue its expectation
    task automatic send_step(input logic [7:0] cur, input logic [1:0] act, input logic [7:0] rew);
        qlg_pkg::item_t   it;
        qlg_pkg::result_t pred;
        it.current_state = cur;
        it.action        = act;
        it.reward        = rew;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        // ready is stable from the falling edge to the next rising edge
        do
            @(negedge clk);
        while (!item_ready);
        pred = predict_q_update(it);
        expected_updates.push_back(pred);
        agent_pos = pred.next_state;
        n_steps++;
        @(posedge clk);
    endtask

    // sender pauses until every expected result is back
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            qlg_pkg::REG_LEARN_RATE:  alpha_reg = val;
            qlg_pkg::REG_DISCOUNT:    gamma_reg = val;
            qlg_pkg::REG_ROW_WIDTH:   row_reg   = val;
            qlg_pkg::REG_START_STATE: start_reg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [8:0] a, input logic [8:0] g,
                                input logic [8:0] rw, input logic [7:0] st);
        write_reg(qlg_pkg::REG_LEARN_RATE, a);
        write_reg(qlg_pkg::REG_DISCOUNT, g);
        write_reg(qlg_pkg::REG_ROW_WIDTH, rw);
        write_reg(qlg_pkg::REG_START_STATE, {1'b0, st});
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [8:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 9'd0;
            1:       return qlg_pkg::RATE_ONE;
            2:       return 9'd511;
            3:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [8:0] pick_row();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(0, 511));
            default: return 9'($urandom_range(1, 20));
        endcase
    endfunction

    // mostly agent trajectories, with scattered jumps and random rewards
    task automatic run_walk(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_step(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            else
                send_step(agent_pos, 2'($urandom_range(0, 3)),
                          ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        end
    endtask

    // reset register values: off-grid in both directions, wrap, episode ends
    task automatic test_reset_defaults();
        send_step(8'd0, qlg_pkg::ACT_ROW_MINUS, 8'd0);
        send_step(8'd255, qlg_pkg::ACT_RIGHT, 8'd0);
        send_step(8'd0, qlg_pkg::ACT_LEFT, 8'd0);
        send_step(8'd11, qlg_pkg::ACT_ROW_PLUS, 8'd0);
        send_step(8'd12, qlg_pkg::ACT_RIGHT, 8'd127);
        send_step(8'd40, qlg_pkg::ACT_LEFT, 8'h80);
        wait_idle();
    endtask

    // rates above one, saturation at both ends
    task automatic test_saturation();
        program_regs(9'd511, 9'd511, 9'd1, 8'd255);
        send_step(8'd5, qlg_pkg::ACT_RIGHT, 8'd127);
        send_step(8'd4, qlg_pkg::ACT_RIGHT, 8'd127);
        send_step(8'd7, qlg_pkg::ACT_ROW_PLUS, 8'h80);
        send_step(8'd7, qlg_pkg::ACT_RIGHT, 8'h80);
        send_step(8'd7, qlg_pkg::ACT_ROW_MINUS, 8'h80);
        send_step(8'd7, qlg_pkg::ACT_LEFT, 8'h80);
        send_step(8'd6, qlg_pkg::ACT_RIGHT, 8'h80);
        wait_idle();
    endtask

    // equal maxima pick the lowest action, a full-table row width leaves the grid
    task automatic test_ties();
        program_regs(qlg_pkg::RATE_ONE, 9'd0, 9'd256, 8'd128);
        send_step(8'd30, qlg_pkg::ACT_ROW_MINUS, 8'd3);
        send_step(8'd30, qlg_pkg::ACT_LEFT, 8'd3);
        send_step(8'd29, qlg_pkg::ACT_RIGHT, 8'd0);
        send_step(8'd0, qlg_pkg::ACT_ROW_PLUS, 8'd0);
        wait_idle();
    endtask

    // zero row width: destination is the current cell, max read before the write
    task automatic test_row_zero();
        program_regs(9'd128, 9'd230, 9'd0, 8'd0);
        send_step(8'd20, qlg_pkg::ACT_ROW_PLUS, 8'd5);
        send_step(8'd20, qlg_pkg::ACT_ROW_MINUS, 8'd0);
        wait_idle();
    endtask

    // zero learning rate keeps the stored value
    task automatic test_rate_zero();
        program_regs(9'd0, qlg_pkg::RATE_ONE, 9'd3, 8'd0);
        send_step(8'd30, qlg_pkg::ACT_ROW_MINUS, 8'd9);
        send_step(8'd100, qlg_pkg::ACT_ROW_PLUS, 8'd0);
        wait_idle();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        program_regs(9'd200, 9'd240, 9'd16, 8'd17);
        agent_pos = start_reg;
        hold_reqs <= hold_reqs + 1;
        run_walk(16);
        wait_idle();
    endtask

    task automatic test_random_walks(input int phases, input int per_phase);
        int p;
        for (p = 0; p < phases; p++)
        begin
            program_regs(pick_rate(), pick_rate(), pick_row(), 8'($urandom_range(0, 255)));
            agent_pos = start_reg;
            run_walk(per_phase);
            wait_idle();
        end
    endtask

    // no idling on either side for the closing stretch
    task automatic test_quiet_tail();
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        program_regs(qlg_pkg::RATE_ONE, qlg_pkg::RATE_ONE, 9'd16, 8'd0);
        agent_pos = start_reg;
        run_walk(300);
        wait_idle();
    endtask

    // receiver: long hold-offs on request, random stall bursts otherwise
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen    <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap       <= rx_gap - 1;
            result_ready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            rx_gap       <= $urandom_range(0, 7);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %0d, got %0d", n_results, name, exp_v, got_v);
        end
    endfunction

    // result transfer happens at the next rising edge, sample in between
    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: %p", result);
            end
            else
            begin
                want = expected_updates.pop_front();
                n_results++;
                check_field("next_state", want.next_state, result.next_state);
                check_field("new_value", want.new_value, result.new_value);
                check_field("best_next_action", want.best_next_action, result.best_next_action);
                check_field("episode_end", want.episode_end, result.episode_end);
                check_field("off_grid", want.off_grid, result.off_grid);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = qlg_pkg::REG_LEARN_RATE;
        cfg_data     = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_reqs    = 0;
        n_steps      = 0;
        n_ends       = 0;
        n_off        = 0;
        n_sat        = 0;
        n_settings   = 1;
        foreach (q_table[i])
            q_table[i] = '0;
        alpha_reg    = 9'd128;
        gamma_reg    = 9'd230;
        row_reg      = 9'd10;
        start_reg    = 8'd11;
        agent_pos    = 8'd11;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation();
        test_ties();
        test_row_zero();
        test_rate_zero();
        test_backpressure();
        test_random_walks(4, 420);
        test_quiet_tail();

        $display("%0d steps and %0d results checked over %0d register settings",
                 n_steps, n_results, n_settings);
        $display("%0d episode ends, %0d off-grid moves, %0d saturated updates",
                 n_ends, n_off, n_sat);
        if (mismatches == 0 && expected_updates.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
